@@ rtl/trrs_pkg.sv @@
package trrs_pkg;

  // action codes
  localparam logic [1:0] ACT_ADD        = 2'd0;
  localparam logic [1:0] ACT_SERVE_HIGH = 2'd1;
  localparam logic [1:0] ACT_SERVE_LOW  = 2'd2;
  localparam logic [1:0] ACT_NONE       = 2'd3;

  // status codes
  localparam logic [1:0] STAT_ACCEPTED = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_RAN      = 2'd2;
  localparam logic [1:0] STAT_EMPTY    = 2'd3;

  // field widths fixed by the interface
  localparam int unsigned IdWidth      = 16;
  localparam int unsigned BurstWidth   = 16;
  localparam int unsigned QuantumWidth = 16;

  localparam logic [QuantumWidth-1:0] QUANTUM_RESET = 16'd4;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_flags_t;

endpackage

@@ rtl/trrs_mem.sv @@
module trrs_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/trrs_queue_ctrl.sv @@
module trrs_queue_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  trrs_pkg::queue_cmd_t     cmd_i,
  output logic [$clog2(DEPTH)-1:0] head_o,
  output logic [$clog2(DEPTH)-1:0] tail_o,
  output trrs_pkg::queue_flags_t   flags_o
);
  import trrs_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (cmd_i.pop) begin
      head_d = (head_q == LastIdx) ? '0 : head_q + IdxW'(1);
    end
    if (cmd_i.push) begin
      tail_d = (tail_q == LastIdx) ? '0 : tail_q + IdxW'(1);
    end
    if (cmd_i.push && !cmd_i.pop) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.pop && !cmd_i.push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  assign head_o        = head_q;
  assign tail_o        = tail_q;
  assign flags_o.empty = (count_q == '0);
  assign flags_o.full  = (count_q == FullCnt);

endmodule

@@ rtl/two_level_rr_fcfs_scheduler.sv @@
// channel   direction  ports                                        handshake
// command   in         action_i task_id_i burst_i high_priority_i   start & !busy
// result    out        status_o ran_id_o run_time_o finished_o      done_o, one cycle
// quantum   in         quantum_wdata_i                              quantum_we_i
//
// add items and serves of an empty queue: result strobes the cycle after accept, busy stays low
// serve of a non-empty queue: the head is read from synchronous memory, busy is high for
// one cycle and the result strobes in the cycle after it; no new item is taken while busy
// a partly run high task is written back to the tail in the busy cycle
// reset clears pointers and counts and sets the quantum to 4; queue memories are not cleared
// the receiver cannot stall: each result is valid for exactly one cycle
module two_level_rr_fcfs_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TIME_WIDTH  = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // command channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           action_i,
  input  logic [trrs_pkg::IdWidth-1:0]         task_id_i,
  input  logic [trrs_pkg::BurstWidth-1:0]      burst_i,
  input  logic                                 high_priority_i,
  // quantum register
  input  logic                                 quantum_we_i,
  input  logic [trrs_pkg::QuantumWidth-1:0]    quantum_wdata_i,
  // result channel
  output logic                                 done_o,
  output logic [1:0]                           status_o,
  output logic [trrs_pkg::IdWidth-1:0]         ran_id_o,
  output logic [trrs_pkg::QuantumWidth-1:0]    run_time_o,
  output logic                                 finished_o
);
  import trrs_pkg::*;

  localparam int unsigned IdxW   = $clog2(QUEUE_DEPTH);
  localparam int unsigned EntryW = IdWidth + TIME_WIDTH;
  // compare width covers both the stored burst and the quantum
  localparam int unsigned CmpW   = (TIME_WIDTH > QuantumWidth) ? TIME_WIDTH : QuantumWidth;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic state_q, state_d;
  logic sel_high_q, sel_high_d;
  logic [QuantumWidth-1:0] quantum_q;

  logic done_q, done_d;
  logic [1:0] status_q, status_d;
  logic [IdWidth-1:0] ran_id_q, ran_id_d;
  logic [QuantumWidth-1:0] run_time_q, run_time_d;
  logic finished_q, finished_d;

  logic accept;

  // queue pointers
  queue_cmd_t   hi_cmd, lo_cmd;
  queue_flags_t hi_flags, lo_flags;
  logic [IdxW-1:0] hi_head, hi_tail, lo_head, lo_tail;

  // memory ports
  logic              hi_we, lo_we;
  logic [EntryW-1:0] hi_wdata, lo_wdata;
  logic [EntryW-1:0] hi_rdata, lo_rdata;

  // incoming item, burst kept in TIME_WIDTH bits
  logic [CmpW-1:0]       burst_ext;
  logic [TIME_WIDTH-1:0] burst_trim;
  logic [EntryW-1:0]     new_entry;

  // head entry being dispatched
  logic [EntryW-1:0]     rd_entry;
  logic [IdWidth-1:0]    rd_id;
  logic [CmpW-1:0]       rd_burst;
  logic [CmpW-1:0]       quantum_ext;
  logic [CmpW-1:0]       slice;
  logic [CmpW-1:0]       remain;
  logic                  reenq;

  assign accept     = start && !busy;
  assign busy       = (state_q == ST_READ);
  assign burst_ext  = CmpW'(burst_i);
  assign burst_trim = burst_ext[TIME_WIDTH-1:0];
  assign new_entry  = {task_id_i, burst_trim};

  // dispatch arithmetic on the head entry read last cycle
  assign rd_entry    = sel_high_q ? hi_rdata : lo_rdata;
  assign rd_id       = rd_entry[EntryW-1 -: IdWidth];
  assign rd_burst    = CmpW'(rd_entry[TIME_WIDTH-1:0]);
  assign quantum_ext = CmpW'(quantum_q);

  always_comb begin
    if (sel_high_q) begin
      slice = (rd_burst < quantum_ext) ? rd_burst : quantum_ext;
    end else begin
      slice = rd_burst;
    end
  end

  assign remain = rd_burst - slice;
  // only high tasks with time left go back to the tail
  assign reenq  = busy && sel_high_q && (remain != '0);

  // memory write and pointer commands
  always_comb begin
    hi_we  = 1'b0;
    lo_we  = 1'b0;
    hi_cmd = '0;
    lo_cmd = '0;
    if (accept && action_i == ACT_ADD) begin
      if (high_priority_i) begin
        hi_we = !hi_flags.full;
      end else begin
        lo_we = !lo_flags.full;
      end
    end
    if (reenq) begin
      hi_we = 1'b1;
    end
    hi_cmd.push = hi_we;
    lo_cmd.push = lo_we;
    hi_cmd.pop  = accept && (action_i == ACT_SERVE_HIGH) && !hi_flags.empty;
    lo_cmd.pop  = accept && (action_i == ACT_SERVE_LOW) && !lo_flags.empty;
  end

  assign hi_wdata = reenq ? {rd_id, remain[TIME_WIDTH-1:0]} : new_entry;
  assign lo_wdata = new_entry;

  // sequencing and result
  always_comb begin
    state_d    = state_q;
    sel_high_d = sel_high_q;
    done_d     = 1'b0;
    status_d   = status_q;
    ran_id_d   = ran_id_q;
    run_time_d = run_time_q;
    finished_d = finished_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (action_i)
            ACT_ADD: begin
              done_d     = 1'b1;
              ran_id_d   = '0;
              run_time_d = '0;
              finished_d = 1'b0;
              if (high_priority_i ? hi_flags.full : lo_flags.full) begin
                status_d = STAT_FULL;
              end else begin
                status_d = STAT_ACCEPTED;
              end
            end
            ACT_SERVE_HIGH, ACT_SERVE_LOW: begin
              sel_high_d = (action_i == ACT_SERVE_HIGH);
              if ((action_i == ACT_SERVE_HIGH) ? hi_flags.empty : lo_flags.empty) begin
                done_d     = 1'b1;
                status_d   = STAT_EMPTY;
                ran_id_d   = '0;
                run_time_d = '0;
                finished_d = 1'b0;
              end else begin
                state_d = ST_READ;
              end
            end
            ACT_NONE: begin
              // unused action: no result, no state change
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        done_d     = 1'b1;
        status_d   = STAT_RAN;
        ran_id_d   = rd_id;
        run_time_d = slice[QuantumWidth-1:0];
        finished_d = !reenq;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      sel_high_q <= 1'b0;
      done_q     <= 1'b0;
      quantum_q  <= QUANTUM_RESET;
    end else begin
      state_q    <= state_d;
      sel_high_q <= sel_high_d;
      done_q     <= done_d;
      if (quantum_we_i) begin
        quantum_q <= quantum_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    ran_id_q   <= ran_id_d;
    run_time_q <= run_time_d;
    finished_q <= finished_d;
  end

  assign done_o     = done_q;
  assign status_o   = status_q;
  assign ran_id_o   = ran_id_q;
  assign run_time_o = run_time_q;
  assign finished_o = finished_q;

  trrs_queue_ctrl #(
    .DEPTH(QUEUE_DEPTH)
  ) u_hi_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (hi_cmd),
    .head_o (hi_head),
    .tail_o (hi_tail),
    .flags_o(hi_flags)
  );

  trrs_queue_ctrl #(
    .DEPTH(QUEUE_DEPTH)
  ) u_lo_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (lo_cmd),
    .head_o (lo_head),
    .tail_o (lo_tail),
    .flags_o(lo_flags)
  );

  trrs_mem #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH(EntryW)
  ) u_hi_mem (
    .clk_i  (clk_i),
    .we_i   (hi_we),
    .waddr_i(hi_tail),
    .wdata_i(hi_wdata),
    .re_i   (hi_cmd.pop),
    .raddr_i(hi_head),
    .rdata_o(hi_rdata)
  );

  trrs_mem #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH(EntryW)
  ) u_lo_mem (
    .clk_i  (clk_i),
    .we_i   (lo_we),
    .waddr_i(lo_tail),
    .wdata_i(lo_wdata),
    .re_i   (lo_cmd.pop),
    .raddr_i(lo_head),
    .rdata_o(lo_rdata)
  );

endmodule

@@ sim/two_level_rr_fcfs_scheduler_test.sv @@
`timescale 1ns / 100ps

module two_level_rr_fcfs_scheduler_test;
  import trrs_pkg::*;

  // sizes of the block and of the run
  localparam int unsigned QueueDepth   = 16;
  localparam int unsigned PtrW         = $clog2(QueueDepth);
  localparam int unsigned PhaseItems   = 205;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned MaxPrinted   = 40;

  // queue select for the scheduler model
  localparam int LowSel  = 0;
  localparam int HighSel = 1;

  // one command item as it sits on the input ports
  typedef struct packed {
    logic [1:0]            action;
    logic [IdWidth-1:0]    task_id;
    logic [BurstWidth-1:0] burst;
    logic                  high_priority;
  } sched_cmd_t;

  // one result item as it comes out of the block
  typedef struct packed {
    logic [1:0]              status;
    logic [IdWidth-1:0]      ran_id;
    logic [QuantumWidth-1:0] run_time;
    logic                    finished;
  } sched_outcome_t;

  // one queue entry: task id and burst still to run
  typedef struct packed {
    logic [IdWidth-1:0]    id;
    logic [BurstWidth-1:0] burst;
  } task_slot_t;

  // flavor of a stretch of random traffic
  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_t;

  // block ports; the inputs are known from time zero
  logic                    clk_i           = 1'b0;
  logic                    rst_ni          = 1'b0;
  logic                    start           = 1'b0;
  logic                    busy;
  logic [1:0]              action_i        = ACT_NONE;
  logic [IdWidth-1:0]      task_id_i       = '0;
  logic [BurstWidth-1:0]   burst_i         = '0;
  logic                    high_priority_i = 1'b0;
  logic                    quantum_we_i    = 1'b0;
  logic [QuantumWidth-1:0] quantum_wdata_i = '0;
  logic                    done_o;
  logic [1:0]              status_o;
  logic [IdWidth-1:0]      ran_id_o;
  logic [QuantumWidth-1:0] run_time_o;
  logic                    finished_o;

  // scheduler model: both queues and the time slice
  task_slot_t              queue_slots [2][QueueDepth];
  logic [PtrW-1:0]         queue_head  [2] = '{default: '0};
  logic [PtrW:0]           queue_count [2] = '{default: '0};
  logic [QuantumWidth-1:0] quantum_now = QUANTUM_RESET;

  // command items waiting for the driver, results still owed by the block
  sched_cmd_t     cmds_waiting [$];
  sched_outcome_t outcomes_due [$];

  // driver and monitor scratch
  sched_cmd_t     on_port;
  sched_cmd_t     next_cmd;
  sched_outcome_t predicted;
  sched_outcome_t want;

  // run bookkeeping
  int unsigned sender_idle_pct = 28;
  int unsigned cycle_count     = 0;
  int unsigned mismatches      = 0;
  int unsigned items_taken     = 0;
  int unsigned results_seen    = 0;
  int unsigned runs_seen       = 0;
  int unsigned finishes_seen   = 0;
  int unsigned drops_seen      = 0;
  int unsigned empties_seen    = 0;
  int unsigned settings_used   = 1;

  two_level_rr_fcfs_scheduler #(
    .QUEUE_DEPTH(QueueDepth),
    .TIME_WIDTH (BurstWidth)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .task_id_i      (task_id_i),
    .burst_i        (burst_i),
    .high_priority_i(high_priority_i),
    .quantum_we_i   (quantum_we_i),
    .quantum_wdata_i(quantum_wdata_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .ran_id_o       (ran_id_o),
    .run_time_o     (run_time_o),
    .finished_o     (finished_o)
  );

  // 2 ns clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // tail write, refused when the queue is full
  function automatic bit queue_push(int sel, task_slot_t entry);
    logic [PtrW-1:0] tail;
    if (queue_count[sel] >= QueueDepth) return 1'b0;
    tail = queue_head[sel] + queue_count[sel][PtrW-1:0];
    queue_slots[sel][tail] = entry;
    queue_count[sel] = queue_count[sel] + 1'b1;
    return 1'b1;
  endfunction

  // head read, only ever called on a non-empty queue
  function automatic task_slot_t queue_pop(int sel);
    task_slot_t entry;
    entry = queue_slots[sel][queue_head[sel]];
    queue_head[sel] = queue_head[sel] + 1'b1;
    queue_count[sel] = queue_count[sel] - 1'b1;
    return entry;
  endfunction

  // advances the model by one command item; returns 0 when no result follows
  function automatic bit predict_outcome(sched_cmd_t cmd, output sched_outcome_t res);
    task_slot_t              entry;
    logic [QuantumWidth-1:0] ran_for;
    res = '0;
    case (cmd.action)
      ACT_ADD: begin
        entry.id    = cmd.task_id;
        entry.burst = cmd.burst;
        res.status  = queue_push(cmd.high_priority ? HighSel : LowSel, entry) ?
                      STAT_ACCEPTED : STAT_FULL;
      end
      ACT_SERVE_HIGH: begin
        if (queue_count[HighSel] == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          // round robin: run one slice, requeue whatever is left
          entry        = queue_pop(HighSel);
          ran_for      = (entry.burst < quantum_now) ? entry.burst : quantum_now;
          entry.burst  = entry.burst - ran_for;
          res.status   = STAT_RAN;
          res.ran_id   = entry.id;
          res.run_time = ran_for;
          if (entry.burst != 0) begin
            void'(queue_push(HighSel, entry));
          end else begin
            res.finished = 1'b1;
          end
        end
      end
      ACT_SERVE_LOW: begin
        if (queue_count[LowSel] == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          // first come first served: the whole burst at once
          entry        = queue_pop(LowSel);
          res.status   = STAT_RAN;
          res.ran_id   = entry.id;
          res.run_time = entry.burst;
          res.finished = 1'b1;
        end
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // random command item; bursts lean toward zero, small, all ones and the slice
  function automatic sched_cmd_t random_cmd(mix_t mix);
    sched_cmd_t  cmd;
    int unsigned roll;
    int unsigned add_pct;
    int          near;
    add_pct = (mix == MIX_FILL) ? 75 : (mix == MIX_DRAIN) ? 25 : 50;
    cmd.task_id       = IdWidth'($urandom);
    cmd.high_priority = 1'($urandom_range(1));
    roll = $urandom_range(99);
    if (roll < 4) begin
      cmd.action = ACT_NONE;
    end else if ($urandom_range(99) < add_pct) begin
      cmd.action = ACT_ADD;
    end else begin
      cmd.action = $urandom_range(1) ? ACT_SERVE_HIGH : ACT_SERVE_LOW;
    end
    roll = $urandom_range(99);
    if (roll < 35) begin
      cmd.burst = BurstWidth'($urandom_range(8));
    end else if (roll < 45) begin
      cmd.burst = '0;
    end else if (roll < 55) begin
      cmd.burst = '1;
    end else if (roll < 70) begin
      // one below, at or one above the slice
      near = int'(quantum_now) - 1 + int'($urandom_range(2));
      if (near < 0) near = 0;
      if (near > 65535) near = 65535;
      cmd.burst = BurstWidth'(near);
    end else begin
      cmd.burst = BurstWidth'($urandom);
    end
    return cmd;
  endfunction

  task automatic stage_cmd(logic [1:0] action, logic [IdWidth-1:0] id,
                           logic [BurstWidth-1:0] burst, logic hp);
    sched_cmd_t cmd;
    cmd.action        = action;
    cmd.task_id       = id;
    cmd.burst         = burst;
    cmd.high_priority = hp;
    cmds_waiting.push_back(cmd);
  endtask

  // nothing queued, nothing on the port, nothing owed, then a settle wait
  // so that an ignored item has left the block too
  task automatic wait_until_idle();
    while (cmds_waiting.size() != 0 || start || outcomes_due.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // slice register write, only while the block is idle
  task automatic write_quantum(logic [QuantumWidth-1:0] value);
    @(posedge clk_i);
    quantum_we_i    <= 1'b1;
    quantum_wdata_i <= value;
    @(posedge clk_i);
    quantum_we_i    <= 1'b0;
    quantum_now      = value;
  endtask

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("mismatch at cycle %0d, result %0d: %s", cycle_count, results_seen, what);
  endtask

  // driver: an item goes in at an edge with start high and busy low
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        // item taken at this edge, predict what it causes
        on_port = {action_i, task_id_i, burst_i, high_priority_i};
        items_taken++;
        if (predict_outcome(on_port, predicted)) outcomes_due.push_back(predicted);
      end
      if (start && busy) begin
        // block still working, hold the item on the port
      end else if (cmds_waiting.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_cmd = cmds_waiting.pop_front();
        start           <= 1'b1;
        action_i        <= next_cmd.action;
        task_id_i       <= next_cmd.task_id;
        burst_i         <= next_cmd.burst;
        high_priority_i <= next_cmd.high_priority;
      end else begin
        // sender gap or nothing left to send
        start <= 1'b0;
      end
    end
  end

  // monitor: each strobe is one result, checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (outcomes_due.size() == 0) begin
        report_mismatch("result strobe with no item outstanding");
      end else begin
        want = outcomes_due.pop_front();
        results_seen++;
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
        if (ran_id_o !== want.ran_id)
          report_mismatch($sformatf("ran_id %h, expected %h", ran_id_o, want.ran_id));
        if (run_time_o !== want.run_time)
          report_mismatch($sformatf("run_time %0d, expected %0d", run_time_o, want.run_time));
        if (finished_o !== want.finished)
          report_mismatch($sformatf("finished %b, expected %b", finished_o, want.finished));
        case (want.status)
          STAT_RAN:   runs_seen++;
          STAT_FULL:  drops_seen++;
          STAT_EMPTY: empties_seen++;
          default: ;
        endcase
        if (want.finished) finishes_seen++;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still owed",
               cycle_count, outcomes_due.size());
      $display("Verification failed");
      $finish;
    end
  end

  // stimulus sequence
  initial begin : stimulus
    int unsigned             taken;
    int unsigned             setting_no;
    logic [QuantumWidth-1:0] slice_value;
    mix_t                    mix;
    sched_cmd_t              cmd;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset slice of 4
    sender_idle_pct = 28;
    stage_cmd(ACT_SERVE_HIGH, 16'h0000, 16'h0000, 1'b1);  // empty high queue
    stage_cmd(ACT_SERVE_LOW,  16'hFFFF, 16'hFFFF, 1'b0);  // empty low queue
    stage_cmd(ACT_NONE,       16'hFFFF, 16'hFFFF, 1'b1);  // unused action, ignored
    stage_cmd(ACT_ADD,        16'hFFFF, 16'hFFFF, 1'b1);  // largest id and burst
    stage_cmd(ACT_ADD,        16'h0000, 16'h0000, 1'b1);  // zero burst in high queue
    stage_cmd(ACT_ADD,        16'h00A5, 16'h0003, 1'b1);  // below the slice
    stage_cmd(ACT_ADD,        16'h5A5A, 16'h0004, 1'b1);  // exactly the slice
    stage_cmd(ACT_ADD,        16'h1234, 16'h0000, 1'b0);  // zero burst in low queue
    stage_cmd(ACT_ADD,        16'hEDCB, 16'hFFFF, 1'b0);
    stage_cmd(ACT_ADD,        16'h0000, 16'h0001, 1'b0);
    stage_cmd(ACT_SERVE_HIGH, 16'hFFFF, 16'hFFFF, 1'b0);  // partial run, requeued
    stage_cmd(ACT_SERVE_HIGH, 16'h0000, 16'h0000, 1'b0);  // zero run, finished
    stage_cmd(ACT_SERVE_HIGH, 16'h0000, 16'h0000, 1'b1);
    stage_cmd(ACT_SERVE_HIGH, 16'h0000, 16'h0000, 1'b1);
    stage_cmd(ACT_SERVE_HIGH, 16'h0000, 16'h0000, 1'b1);  // requeued task again
    stage_cmd(ACT_SERVE_LOW,  16'h0000, 16'h0000, 1'b1);
    stage_cmd(ACT_SERVE_LOW,  16'h0000, 16'h0000, 1'b0);
    stage_cmd(ACT_SERVE_LOW,  16'h0000, 16'h0000, 1'b0);
    stage_cmd(ACT_SERVE_LOW,  16'h0000, 16'h0000, 1'b0);  // low queue drained
    stage_cmd(ACT_NONE,       16'h0000, 16'h0000, 1'b0);
    stage_cmd(ACT_SERVE_HIGH, 16'h0000, 16'h0000, 1'b0);
    wait_until_idle();

    // random part, one slice setting per stretch
    for (setting_no = 0; setting_no < RandomPhases; setting_no++) begin
      case (setting_no)
        0:       slice_value = 16'd1;
        1:       slice_value = 16'hFFFF;
        2:       slice_value = 16'd0;     // high tasks never progress
        3:       slice_value = 16'd3;
        4:       slice_value = 16'd2;
        6:       slice_value = 16'd8;
        default: slice_value = QuantumWidth'($urandom_range(65535, 1));
      endcase
      // sender gaps: light, then heavy, then none
      sender_idle_pct = (setting_no < 3) ? 28 : (setting_no < 6) ? 84 : 0;
      write_quantum(slice_value);
      settings_used++;

      // stretches that fill, drain or balance, so both queues go full and empty
      taken = 0;
      mix   = MIX_EVEN;
      while (taken < PhaseItems) begin
        if (taken % 30 == 0) begin
          case ($urandom_range(2))
            0:       mix = MIX_FILL;
            1:       mix = MIX_DRAIN;
            default: mix = MIX_EVEN;
          endcase
        end
        cmd = random_cmd(mix);
        cmds_waiting.push_back(cmd);
        if (cmd.action != ACT_NONE) taken++;
      end
      wait_until_idle();
    end

    $display("%0d command items over %0d slice settings, %0d results checked",
             items_taken, settings_used, results_seen);
    $display("%0d dispatches (%0d finished), %0d dropped on full, %0d served empty",
             runs_seen, finishes_seen, drops_seen, empties_seen);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
